// File: hdl/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// Shared widths, codes and controller/datapath handshake types for the
// keyframe track playback block.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int MAX_KEYS_DEF     = 64;

  localparam int CMD_W      = 2;
  localparam int DELTA_W    = 20;
  localparam int TIME_W     = 31;
  localparam int POS_W      = 32;
  localparam int TPS_W      = 24;
  localparam int CIU_W      = 5;
  localparam int CHF_W      = 4;
  localparam int KEYF_W     = 6;
  localparam int STAT_W     = 2;
  localparam int RATE_FRAC  = 8;
  localparam int PROD_W     = TPS_W + DELTA_W;
  localparam int ADD_W      = PROD_W - RATE_FRAC;
  localparam int SUM_W      = ADD_W + 2;
  localparam int REPORT_MAX = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [TPS_W-1:0] TPS_RST = TPS_W'(256);
  localparam logic [CIU_W-1:0] CIU_RST = CIU_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLAY   = 2'd0,
    ST_LOOP   = 2'd1,
    ST_FINISH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_TPS      = 2'd1,
    REG_CHANNELS = 2'd2
  } reg_t;

  typedef struct packed {
    logic take_tick;
    logic load_key;
    logic clear_track;
    logic mul_go;
    logic sum_go;
    logic hit_go;
    logic apply;
    logic ch_init;
    logic probe;
    logic cmp;
    logic fin;
    logic emit;
    logic emit_last;
  } kft_cmd_t;

  typedef struct packed {
    logic probe_more;
    logic out_free;
  } kft_sts_t;

endpackage

// File: hdl/kft_in_if.sv
// ----------------------------------------------------------------------------
// kft_in_if
// Input word channel: tick, keyframe load and track clear commands.
// ----------------------------------------------------------------------------
interface kft_in_if import kft_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [DELTA_W-1:0]  time_delta;
  logic                loop_enable;
  logic                end_valid;
  logic [TIME_W-1:0]   end_position;
  logic [CHF_W-1:0]    channel;
  logic [KEYF_W-1:0]   key_index;
  logic [TIME_W-1:0]   key_time;
  logic                key_last;

  modport source (
    output valid, cmd, time_delta, loop_enable, end_valid, end_position,
           channel, key_index, key_time, key_last,
    input  ready
  );
  modport sink (
    input  valid, cmd, time_delta, loop_enable, end_valid, end_position,
           channel, key_index, key_time, key_last,
    output ready
  );
endinterface

// File: hdl/kft_out_if.sv
// ----------------------------------------------------------------------------
// kft_out_if
// Result word channel: one word per reported channel per tick.
// ----------------------------------------------------------------------------
interface kft_out_if import kft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CHF_W-1:0]   out_channel;
  logic [KEYF_W-1:0]  keyframe_index;
  logic               last;

  modport source (
    output valid, status, out_channel, keyframe_index, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_channel, keyframe_index, last,
    output ready
  );
endinterface

// File: hdl/kft_cfg_regs.sv
// ----------------------------------------------------------------------------
// kft_cfg_regs
// APB register file: duration, tick rate and reported channel count.
// ----------------------------------------------------------------------------
module kft_cfg_regs import kft_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [TIME_W-1:0] duration,
  output logic [TPS_W-1:0]  ticks_per_second,
  output logic [CIU_W-1:0]  report_n
);

  localparam int RPT_LIM = (NUM_CHANNELS < REPORT_MAX) ? NUM_CHANNELS : REPORT_MAX;

  logic [CIU_W-1:0] channels_in_use;
  logic             wr;
  reg_t             sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration         <= '0;
      ticks_per_second <= TPS_RST;
      channels_in_use  <= CIU_RST;
    end else if (wr) begin
      unique case (sel)
        REG_DURATION: duration         <= pwdata[TIME_W-1:0];
        REG_TPS:      ticks_per_second <= pwdata[TPS_W-1:0];
        REG_CHANNELS: channels_in_use  <= pwdata[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DURATION: prdata = APB_DW'(duration);
      REG_TPS:      prdata = APB_DW'(ticks_per_second);
      REG_CHANNELS: prdata = APB_DW'(channels_in_use);
      default:      prdata = '0;
    endcase
  end

  // clamp the reported count to 1 .. min(16, channels)
  always_comb begin
    if (channels_in_use == '0) begin
      report_n = CIU_W'(1);
    end else if (32'(channels_in_use) > RPT_LIM) begin
      report_n = CIU_W'(RPT_LIM);
    end else begin
      report_n = channels_in_use;
    end
  end

endmodule

// File: hdl/kft_ctrl.sv
// ----------------------------------------------------------------------------
// kft_ctrl
// Sequencer: position update steps, then a per-channel search and report.
// ----------------------------------------------------------------------------
module kft_ctrl import kft_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  logic [CIU_W-1:0] report_n,
  input  kft_sts_t         sts,
  output kft_cmd_t         cmd,
  output logic [CHW-1:0]   ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_HIT,
    S_APPLY,
    S_CH_INIT,
    S_SEARCH,
    S_CMP,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   reported;
  logic   last_ch;
  cmd_t   in_code;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_code  = cmd_t'(in_cmd);
  assign reported = 32'(ch) < 32'(report_n);
  assign last_ch  = (ch == CHW'(NUM_CHANNELS - 1));

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take_tick   = accept && (in_code == CMD_TICK);
        cmd.load_key    = accept && (in_code == CMD_LOAD);
        cmd.clear_track = accept && (in_code == CMD_CLEAR);
      end
      S_MUL:     cmd.mul_go  = 1'b1;
      S_SUM:     cmd.sum_go  = 1'b1;
      S_HIT:     cmd.hit_go  = 1'b1;
      S_APPLY:   cmd.apply   = 1'b1;
      S_CH_INIT: cmd.ch_init = 1'b1;
      S_SEARCH:  cmd.probe   = sts.probe_more;
      S_CMP:     cmd.cmp     = 1'b1;
      S_FIN:     cmd.fin     = 1'b1;
      S_EMIT: begin
        cmd.emit      = reported && sts.out_free;
        cmd.emit_last = 32'(ch) + 32'd1 == 32'(report_n);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && in_code == CMD_TICK) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_HIT;
        S_HIT:   state <= S_APPLY;
        S_APPLY: begin
          ch    <= '0;
          state <= S_CH_INIT;
        end
        S_CH_INIT: state <= S_SEARCH;
        S_SEARCH:  state <= sts.probe_more ? S_CMP : S_FIN;
        S_CMP:     state <= S_SEARCH;
        S_FIN:     state <= S_EMIT;
        S_EMIT: begin
          // for a reported channel, hold until the output register can take the word
          if (!reported || sts.out_free) begin
            if (last_ch) begin
              ch    <= '0;
              state <= S_IDLE;
            end else begin
              ch    <= ch + CHW'(1);
              state <= S_CH_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/kft_dp.sv
// ----------------------------------------------------------------------------
// kft_dp
// Datapath: track position arithmetic, keyframe time memory, per-channel
// counts and indices, binary search registers and the result register.
// ----------------------------------------------------------------------------
module kft_dp import kft_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int MAX_KEYS     = MAX_KEYS_DEF,
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  kft_cmd_t           cmd,
  output kft_sts_t           sts,
  input  logic [CHW-1:0]     ch,
  input  logic [TIME_W-1:0]  duration,
  input  logic [TPS_W-1:0]   ticks_per_second,
  input  logic [DELTA_W-1:0] time_delta,
  input  logic               loop_enable,
  input  logic               end_valid,
  input  logic [TIME_W-1:0]  end_position,
  input  logic [CHF_W-1:0]   channel,
  input  logic [KEYF_W-1:0]  key_index,
  input  logic [TIME_W-1:0]  key_time,
  input  logic               key_last,
  kft_out_if.source          result
);

  localparam int DEPTH = NUM_CHANNELS * MAX_KEYS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_KEYS);
  localparam int KW    = $clog2(MAX_KEYS + 1);

  logic [TIME_W-1:0]  key_mem [DEPTH];
  logic [TIME_W-1:0]  rdata;
  logic [KW-1:0]      key_cnt [NUM_CHANNELS];
  logic [IW-1:0]      cur_idx [NUM_CHANNELS];

  logic [DELTA_W-1:0]    delta_r;
  logic                  loop_r;
  logic                  endv_r;
  logic [TIME_W-1:0]     endp_r;
  logic [PROD_W-1:0]     prod_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] diff_r;
  logic                  hit_r;
  logic signed [POS_W-1:0] pos;
  status_t               status_r;

  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] lim;
  logic [IW-1:0] mid_r;
  logic          short_r;

  logic               load_ok;
  logic [AW-1:0]      load_addr;
  logic [AW-1:0]      probe_addr;
  logic [IW-1:0]      mid;
  logic [KW-1:0]      cnt_cur;
  logic [IW-1:0]      fin_idx;
  logic [IW-1:0]      lo_dec;
  logic               key_le;
  logic signed [SUM_W-1:0] dur_ext;
  logic signed [SUM_W-1:0] endp_ext;
  logic signed [POS_W-1:0] pos_sat;

  assign load_ok   = (32'(channel) < NUM_CHANNELS) && (32'(key_index) < MAX_KEYS);
  assign load_addr = AW'(32'(channel) * 32'(MAX_KEYS) + 32'(key_index));
  assign mid       = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign probe_addr = AW'(32'(ch) * 32'(MAX_KEYS) + 32'(mid));
  assign cnt_cur   = key_cnt[ch];
  assign dur_ext   = $signed({{(SUM_W - TIME_W){1'b0}}, duration});
  assign endp_ext  = $signed({{(SUM_W - TIME_W){1'b0}}, endp_r});
  assign key_le    = $signed({1'b0, rdata}) <= pos;

  assign lo_dec  = (lo == '0) ? '0 : lo - IW'(1);
  assign fin_idx = (lo_dec >= lim) ? lim : lo_dec;

  // saturate the looped position to the signed 32-bit range
  always_comb begin
    if (diff_r[SUM_W-1:POS_W-1] == '0 || diff_r[SUM_W-1:POS_W-1] == '1) begin
      pos_sat = diff_r[POS_W-1:0];
    end else if (diff_r[SUM_W-1]) begin
      pos_sat = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W - 1){1'b1}}};
    end
  end

  assign sts.probe_more = !short_r && (lo < hi);
  assign sts.out_free   = !result.valid || result.ready;

  // keyframe time memory: one write port for loads, one read port for probes
  always_ff @(posedge clk) begin
    if (cmd.load_key && load_ok) begin
      key_mem[load_addr] <= key_time;
    end
    if (cmd.probe) begin
      rdata <= key_mem[probe_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        key_cnt[i] <= '0;
      end
    end else if (cmd.load_key && load_ok && key_last) begin
      key_cnt[CHW'(channel)] <= KW'(32'(key_index) + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur_idx[i] <= '0;
      end
    end else if (cmd.clear_track || (cmd.apply && hit_r && loop_r)) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur_idx[i] <= '0;
      end
    end else if (cmd.fin && !short_r) begin
      cur_idx[ch] <= fin_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      status_r <= ST_PLAY;
    end else if (cmd.clear_track) begin
      pos <= '0;
    end else if (cmd.apply) begin
      if (!hit_r) begin
        pos      <= sum_r[POS_W-1:0];
        status_r <= ST_PLAY;
      end else if (loop_r) begin
        pos      <= pos_sat;
        status_r <= ST_LOOP;
      end else begin
        status_r <= ST_FINISH;
      end
    end
  end

  // tick arithmetic: multiply, add, then compare against the end points
  always_ff @(posedge clk) begin
    if (cmd.take_tick) begin
      delta_r <= time_delta;
      loop_r  <= loop_enable;
      endv_r  <= end_valid;
      endp_r  <= end_position;
    end
    if (cmd.mul_go) begin
      prod_r <= PROD_W'(ticks_per_second) * PROD_W'(delta_r);
    end
    if (cmd.sum_go) begin
      sum_r <= $signed({{(SUM_W - POS_W){pos[POS_W-1]}}, pos})
             + $signed({2'b00, prod_r[PROD_W-1:RATE_FRAC]});
    end
    if (cmd.hit_go) begin
      hit_r  <= (sum_r >= dur_ext) || (endv_r && (sum_r >= endp_ext));
      diff_r <= sum_r - dur_ext;
    end
  end

  // binary search registers
  always_ff @(posedge clk) begin
    if (cmd.ch_init) begin
      lo      <= cur_idx[ch];
      hi      <= IW'(cnt_cur - KW'(1));
      lim     <= IW'(cnt_cur - KW'(1));
      short_r <= cnt_cur <= KW'(1);
    end else if (cmd.probe) begin
      mid_r <= mid;
    end else if (cmd.cmp) begin
      if (key_le) begin
        lo <= mid_r + IW'(1);
      end else begin
        hi <= mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status         <= status_r;
      result.out_channel    <= CHF_W'(ch);
      result.keyframe_index <= KEYF_W'(cur_idx[ch]);
      result.last           <= cmd.emit_last;
    end
  end

endmodule

// File: hdl/keyframe_track_playback.sv
// ----------------------------------------------------------------------------
// keyframe_track_playback
// Animation track timer with a per-channel keyframe binary search.
// ----------------------------------------------------------------------------
// Load words and clear words are taken while idle and return nothing. A tick
// word first advances the track position (multiply, add, end compare,
// update), then walks every channel in turn: init, search, finish and emit
// steps per channel. A channel with k keyframes needs up to ceil(log2(k))
// search probes; each probe is a registered read of the keyframe time
// memory followed by a compare. The walk stalls while the result sink holds
// off a reported word. The input takes no new word until the walk has
// finished the last channel of a tick. Keyframe times are undefined until
// loaded; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module keyframe_track_playback import kft_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int MAX_KEYS     = MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  kft_in_if.sink            item,
  kft_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [TIME_W-1:0] duration;
  logic [TPS_W-1:0]  ticks_per_second;
  logic [CIU_W-1:0]  report_n;
  logic              in_ready;
  kft_cmd_t          cmd;
  kft_sts_t          sts;
  logic [CHW-1:0]    ch;

  assign item.ready = in_ready;

  kft_cfg_regs #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .duration         (duration),
    .ticks_per_second (ticks_per_second),
    .report_n         (report_n)
  );

  kft_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .in_ready (in_ready),
    .report_n (report_n),
    .sts      (sts),
    .cmd      (cmd),
    .ch       (ch)
  );

  kft_dp #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .MAX_KEYS    (MAX_KEYS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .ch               (ch),
    .duration         (duration),
    .ticks_per_second (ticks_per_second),
    .time_delta       (item.time_delta),
    .loop_enable      (item.loop_enable),
    .end_valid        (item.end_valid),
    .end_position     (item.end_position),
    .channel          (item.channel),
    .key_index        (item.key_index),
    .key_time         (item.key_time),
    .key_last         (item.key_last),
    .result           (result)
  );

endmodule

// File: hdl/kft_checker.sv
// ----------------------------------------------------------------------------
// kft_checker
// Port-level checks on tick sequencing and result ordering.
// ----------------------------------------------------------------------------
module kft_checker import kft_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [CHF_W-1:0]  out_channel,
  input logic              out_last
);

  logic [CHF_W-1:0]  exp_ch;
  logic [STAT_W-1:0] hold_status;
  logic              out_take;

  assign out_take = out_valid && out_ready;

  // track the channel expected next and the status of the current tick
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ch      <= '0;
      hold_status <= '0;
    end else if (out_take) begin
      exp_ch      <= out_last ? '0 : exp_ch + CHF_W'(1);
      hold_status <= out_status;
    end
  end

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_TICK |=> !in_ready)
    else $error("input still ready right after a tick word");

  a_chan_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_channel == exp_ch)
    else $error("result channel out of order");

  a_tick_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && exp_ch != '0 |-> out_status == hold_status)
    else $error("status changed within one tick");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_status))
    else $error("stalled result word changed");

endmodule

bind keyframe_track_playback kft_checker u_kft_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .in_cmd      (item.cmd),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_status  (result.status),
  .out_channel (result.out_channel),
  .out_last    (result.last)
);
